[src/phb_pkg.sv]
// Shared types and constants for the partitioned histogram unit.
package phb_pkg;

  localparam int CMD_W      = 2;
  localparam int PIX_W      = 32;
  localparam int PART_W     = 2;
  localparam int CIDX_W     = 10;
  localparam int CNT_OUT_W  = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam int SHIFT_W    = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_BUILD = 2'd0,
    CMD_INDEX = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RANGE_MIN = 1'b0,
    REG_RANGE_MAX = 1'b1
  } cfg_reg_t;

  // item on its way to the counter bank
  typedef struct packed {
    logic              vld;
    cmd_t              cmd;
    logic [CIDX_W-1:0] cidx;
  } item_ctl_t;

  // finished result from the counter bank
  typedef struct packed {
    logic                 vld;
    logic [CIDX_W-1:0]    cidx;
    logic [CNT_OUT_W-1:0] count;
  } result_t;

endpackage

[src/phb_bin_map.sv]
// Bin mapping: range compare stage, bin shift and counter address.
module phb_bin_map import phb_pkg::*; #(
  parameter int NUM_HIST = 4,
  parameter int NUM_BINS = 256,
  parameter int AW       = 10
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     advance,
  input  logic                     in_fire,
  input  cmd_t                     in_cmd,
  input  logic signed [PIX_W-1:0]  in_pixel,
  input  logic [PART_W-1:0]        in_part,
  input  logic signed [PIX_W-1:0]  range_min,
  input  logic signed [PIX_W-1:0]  range_max,
  output item_ctl_t                rd_ctl,
  output logic [AW-1:0]            rd_slot
);

  localparam int BW    = $clog2(NUM_BINS);
  localparam int LOG2B = $clog2(NUM_BINS + 1) - 1;
  localparam int IDXW  = PART_W + BW;
  localparam logic [PIX_W-1:0] LAST_BIN = PIX_W'(NUM_BINS - 1);

  function automatic logic [SHIFT_W-1:0] ceil_log2(input logic [PIX_W-1:0] v);
    logic [PIX_W-1:0]   m;
    logic [SHIFT_W-1:0] s;
    m = v - PIX_W'(1);
    s = '0;
    for (int i = 0; i < PIX_W; i++) begin
      if (m[i]) s = SHIFT_W'(i + 1);
    end
    return (v > PIX_W'(1)) ? s : '0;
  endfunction

  logic                a_vld_r;
  cmd_t                a_cmd_r;
  logic [PART_W-1:0]   a_part_r;
  logic                a_above_r;
  logic                a_below_r;
  logic [PIX_W-1:0]    a_diff_r;
  logic [PIX_W-1:0]    w_r;
  logic [SHIFT_W-1:0]  sh_r;

  logic signed [PIX_W:0] span;
  logic [PIX_W-1:0]      w_nxt;
  logic [PART_W-1:0]     part_nxt;
  logic [PIX_W-1:0]      shifted;
  logic [BW-1:0]         bin;
  logic [IDXW-1:0]       cidx_wide;

  // bin width and shift follow the range registers, two register steps
  always_comb begin
    span  = (PIX_W+1)'(range_max) - (PIX_W+1)'(range_min);
    w_nxt = span[PIX_W] ? '0 : (span[PIX_W-1:0] >> LOG2B);
  end

  always_ff @(posedge clk) begin
    w_r  <= w_nxt;
    sh_r <= ceil_log2(w_r);
  end

  always_comb begin
    part_nxt = in_part;
    if (32'(in_part) > 32'(NUM_HIST - 1)) part_nxt = PART_W'(NUM_HIST - 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (advance) begin
      a_vld_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_fire) begin
      a_cmd_r   <= in_cmd;
      a_part_r  <= part_nxt;
      a_above_r <= in_pixel > range_max;
      a_below_r <= in_pixel < range_min;
      a_diff_r  <= PIX_W'(in_pixel - range_min);
    end
  end

  always_comb begin
    shifted = a_diff_r >> sh_r;
    if (a_above_r) begin
      bin = BW'(LAST_BIN);
    end else if (a_below_r) begin
      bin = '0;
    end else if (shifted > LAST_BIN) begin
      bin = BW'(LAST_BIN);
    end else begin
      bin = BW'(shifted);
    end
    cidx_wide   = {a_part_r, bin};
    rd_slot     = AW'(32'(a_part_r) * 32'(NUM_BINS) + 32'(bin));
    rd_ctl.vld  = a_vld_r;
    rd_ctl.cmd  = a_cmd_r;
    rd_ctl.cidx = CIDX_W'(cidx_wide);
  end

endmodule

[src/phb_bank.sv]
// Counter memory with read-modify-write, write forwarding and clearing sweep.
module phb_bank import phb_pkg::*; #(
  parameter int AW    = 10,
  parameter int CW    = 32,
  parameter int DEPTH = 1024
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          advance,
  input  item_ctl_t     rd_ctl,
  input  logic [AW-1:0] rd_slot,
  output result_t       res,
  output logic          sweep_busy,
  output logic          clear_fire
);

  localparam int WW = CW + 1;
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  // word = {written flag, count}
  logic [WW-1:0] mem [DEPTH];

  item_ctl_t     b_ctl_r;
  logic [AW-1:0] b_slot_r;
  logic [WW-1:0] rd_q_r;
  logic          fwd_vld_r;
  logic [AW-1:0] fwd_addr_r;
  logic [WW-1:0] fwd_word_r;
  logic          sweep_r;
  logic [AW-1:0] sweep_ptr_r;

  logic [WW-1:0] word;
  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_inc;
  logic          fire;
  logic          upd;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [WW-1:0] wr_word;

  always_ff @(posedge clk) begin
    if (advance) rd_q_r <= mem[rd_slot];
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_word;
  end

  always_comb begin
    // last update was not yet visible to the read issued alongside it
    word    = (fwd_vld_r && (fwd_addr_r == b_slot_r)) ? fwd_word_r : rd_q_r;
    cnt     = word[CW] ? word[CW-1:0] : '0;
    cnt_inc = (&cnt) ? cnt : cnt + CW'(1);
    fire       = advance && b_ctl_r.vld;
    upd        = fire && (b_ctl_r.cmd == CMD_BUILD);
    clear_fire = fire && (b_ctl_r.cmd == CMD_CLEAR);
    wr_en   = sweep_r || upd;
    wr_addr = sweep_r ? sweep_ptr_r : b_slot_r;
    wr_word = sweep_r ? '0 : {1'b1, cnt_inc};
  end

  always_comb begin
    res.vld   = b_ctl_r.vld;
    res.cidx  = '0;
    res.count = '0;
    case (b_ctl_r.cmd)
      CMD_BUILD: res.cidx = b_ctl_r.cidx;
      CMD_INDEX: begin
        res.cidx  = b_ctl_r.cidx;
        res.count = CNT_OUT_W'(cnt);
      end
      default: ;
    endcase
  end

  assign sweep_busy = sweep_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_ctl_r     <= '0;
      fwd_vld_r   <= 1'b0;
      sweep_r     <= 1'b1;
      sweep_ptr_r <= '0;
    end else begin
      if (advance) b_ctl_r <= rd_ctl;
      if (clear_fire) begin
        fwd_vld_r <= 1'b0;
      end else if (upd) begin
        fwd_vld_r <= 1'b1;
      end
      if (clear_fire) begin
        sweep_r     <= 1'b1;
        sweep_ptr_r <= '0;
      end else if (sweep_r) begin
        if (sweep_ptr_r == LAST_SLOT) begin
          sweep_r <= 1'b0;
        end else begin
          sweep_ptr_r <= sweep_ptr_r + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) b_slot_r <= rd_slot;
    if (upd) begin
      fwd_addr_r <= b_slot_r;
      fwd_word_r <= wr_word;
    end
  end

endmodule

[src/partitioned_histogram_backproject_unit.sv]
// Top level of the partitioned histogram / back-projection unit.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-------------------------------------
//   in_     | input     | in_valid/in_ready   | in_cmd, in_pixel_value, in_partition_select
//   out_    | output    | out_valid/out_ready | out_combined_index, out_bin_count
//   cfg_    | input     | cfg_we (no wait)    | cfg_index, cfg_wdata
//
// One pixel per cycle sustained while nothing holds the input off; a transfer
// passes the range stage (loaded at the accepting edge), the memory read stage
// and the output register, from which its result can transfer.
// Counter memory: one read and one write port; back-to-back builds on the same
// bin are served by forwarding the last written word.
// Reset and every clear command run a sweep over NUM_HIST*NUM_BINS entries,
// one per cycle, with the input held off; a clear also waits for the sweep.
// A config write holds the input off while the bin shift settles.
// A stalled output stalls the whole pipe.
module partitioned_histogram_backproject_unit import phb_pkg::*; #(
  parameter int NUM_HIST    = 4,
  parameter int NUM_BINS    = 256,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [CMD_W-1:0]         in_cmd,
  input  logic signed [PIX_W-1:0]  in_pixel_value,
  input  logic [PART_W-1:0]        in_partition_select,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [CIDX_W-1:0]        out_combined_index,
  output logic [CNT_OUT_W-1:0]     out_bin_count,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int TOTAL = NUM_HIST * NUM_BINS;
  localparam int AW    = $clog2(TOTAL);

  logic signed [PIX_W-1:0] range_min_r;
  logic signed [PIX_W-1:0] range_max_r;
  logic                    settle_r;
  logic                    clear_pend_r;
  logic                    out_valid_r;
  logic [CIDX_W-1:0]       out_cidx_r;
  logic [CNT_OUT_W-1:0]    out_count_r;

  logic          advance;
  logic          in_fire;
  cmd_t          cmd;
  item_ctl_t     rd_ctl;
  logic [AW-1:0] rd_slot;
  result_t       res;
  logic          sweep_busy;
  logic          clear_fire;

  // whole pipe moves unless a result sits unclaimed
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = advance && !sweep_busy && !clear_pend_r && !settle_r;
  assign in_fire  = in_valid && in_ready;
  assign cmd      = cmd_t'(in_cmd);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_min_r <= PIX_W'(0);
      range_max_r <= PIX_W'(255);
      settle_r    <= 1'b0;
    end else begin
      settle_r <= cfg_we;
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_RANGE_MIN: range_min_r <= cfg_wdata;
          REG_RANGE_MAX: range_max_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // a clear holds the input off until its sweep has started (then sweep_busy)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_pend_r <= 1'b0;
    end else if (clear_fire) begin
      clear_pend_r <= 1'b0;
    end else if (in_fire && (cmd == CMD_CLEAR)) begin
      clear_pend_r <= 1'b1;
    end
  end

  phb_bin_map #(
    .NUM_HIST (NUM_HIST),
    .NUM_BINS (NUM_BINS),
    .AW       (AW)
  ) u_bin_map (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .in_fire   (in_fire),
    .in_cmd    (cmd),
    .in_pixel  (in_pixel_value),
    .in_part   (in_partition_select),
    .range_min (range_min_r),
    .range_max (range_max_r),
    .rd_ctl    (rd_ctl),
    .rd_slot   (rd_slot)
  );

  phb_bank #(
    .AW    (AW),
    .CW    (COUNT_WIDTH),
    .DEPTH (TOTAL)
  ) u_bank (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .rd_ctl     (rd_ctl),
    .rd_slot    (rd_slot),
    .res        (res),
    .sweep_busy (sweep_busy),
    .clear_fire (clear_fire)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.vld) begin
      out_cidx_r  <= res.cidx;
      out_count_r <= res.count;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_combined_index = out_cidx_r;
  assign out_bin_count      = out_count_r;

`ifndef SYNTH
  // no transfer while the counter sweep runs
  a_sweep_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    sweep_busy |-> !in_ready)
    else $error("input accepted during counter sweep");

  // a clear admits nothing behind it until the sweep has run
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (cmd == CMD_CLEAR)) |=> !in_ready)
    else $error("input accepted behind a pending clear");

  // config write holds the input off for the shift to settle
  a_cfg_settle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_ready)
    else $error("input accepted right after config write");

  // clear result carries zero fields
  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    clear_fire |=> (out_valid && (out_combined_index == '0) && (out_bin_count == '0)))
    else $error("clear result not zero");
`endif

endmodule
